// ===== hdl/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge
`define LSFT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define LSFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lsft_pkg.sv =====
package lsft_pkg;

	// request codes
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_SHOW  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_BUSY  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_LED_COUNT  = 2'd0;
	localparam logic [1:0] REG_PLAIN_RGB  = 2'd1;
	localparam logic [1:0] REG_HALF_TICKS = 2'd2;
	localparam logic [1:0] REG_CS_USED    = 2'd3;

	localparam logic [7:0]  LED_HDR   = 8'hE0;
	localparam logic [7:0]  PAD_BYTE  = 8'h00;
	localparam logic [31:0] END_WORD  = 32'hFFFF_FFFF;
	localparam logic [31:0] START_WORD = 32'h0000_0000;

	typedef struct packed {
		logic       sck;
		logic       mosi;
		logic       cs_n;
		logic       busy_res;
		logic [1:0] status;
	} res_t;

	// (w*31+127)/255, the divide done as a multiply by 16449 and a shift by 22
	function automatic logic [4:0] scale_brightness(input logic [7:0] w);
		logic [12:0] x;
		logic [27:0] p;
		x = 13'({w, 5'b0}) - 13'(w) + 13'd127;
		p = (28'(x) << 14) + (28'(x) << 6) + 28'(x);
		return p[26:22];
	endfunction

	function automatic logic [31:0] make_led_word(input logic rgb_mode, input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b, input logic [7:0] w);
		logic [31:0] word;
		if (rgb_mode) begin
			word = {r, g, b, PAD_BYTE};
		end else begin
			word = {LED_HDR | {3'b000, scale_brightness(w)}, b, g, r};
		end
		return word;
	endfunction

endpackage

// ===== hdl/lsft_if.sv =====
// request channel
interface lsft_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [10:0] pixel_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  brightness;

	modport source (output valid, req_type, pixel_index, red, green, blue, brightness,
		input ready);
	modport sink (input valid, req_type, pixel_index, red, green, blue, brightness,
		output ready);
endinterface

// result channel
interface lsft_res_if;
	logic       valid;
	logic       ready;
	logic       sck;
	logic       mosi;
	logic       cs_n;
	logic       busy_res;
	logic [1:0] status;

	modport source (output valid, sck, mosi, cs_n, busy_res, status, input ready);
	modport sink (input valid, sck, mosi, cs_n, busy_res, status, output ready);
endinterface

// ===== hdl/led_strip_spi_frame_transmitter.sv =====
// led strip frame transmitter: pixel store plus a serialiser for apa102-style strips
// req channel: one transfer per request; req_type tick, write pixel or start show
//   write stores one led word at pixel_index (refused past the led count)
//   show starts a frame: start word, led words in index order, end word
//   tick advances the serial line by one divider step
// res channel: one result per request, registered; sck, mosi, cs_n and busy_res show
//   the line after the request, status gives ok, index out of range or show refused
// throughput: one request per cycle while req.ready is high; each request is a single
//   pass through the next-state logic; the store is read one word ahead of the shifter
// stall: a two-entry output stage (result register plus skid) lets one more request
//   in while a result waits; req.ready drops when both are full or while clearing
// reset: arst_n clears the control state and then a clearing pass writes zero to
//   every store entry in turn, with req.ready low; apb writes are taken
// apb: registers at byte addresses 0 led_count, 4 plain_rgb_mode,
//   8 half_period_ticks, 12 chip_select_used; pready is always high
module led_strip_spi_frame_transmitter import lsft_pkg::*; #(
	parameter int MAX_LEDS = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	lsft_req_if.sink    req,
	lsft_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int FW  = $clog2(MAX_LEDS + 1);
	localparam int WPW = $clog2(MAX_LEDS + 3);

	// configuration registers
	logic [11:0] led_count_q;
	logic        plain_rgb_q;
	logic [15:0] half_ticks_q;
	logic        cs_used_q;

	// serialiser state
	logic [31:0]    shift_q;
	logic [4:0]     bits_q;
	logic [WPW-1:0] wp_q;
	logic [15:0]    div_q;
	logic           clk_lvl_q;
	logic           active_q;
	logic [FW-1:0]  frame_q;

	// clearing pass
	logic          clearing_q;
	logic [AW-1:0] clr_idx_q;

	// output stage
	logic res_valid_q;
	logic skid_valid_q;
	res_t res_q;
	res_t skid_q;

	logic in_acc;
	logic drain;
	logic cfg_wr;

	// next-state values
	logic [31:0]    shift_d;
	logic [4:0]     bits_d;
	logic [WPW-1:0] wp_d;
	logic [15:0]    div_d;
	logic           clk_lvl_d;
	logic           active_d;
	logic [FW-1:0]  frame_d;
	logic [1:0]     status_d;
	res_t           res_d;

	logic [FW-1:0]  eff_count;
	logic [15:0]    half;
	logic [15:0]    div_inc;
	logic [WPW-1:0] wp_inc;
	logic           idx_ok;

	// pixel store ports
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [31:0]   ram_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// apb register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q  <= 12'd1;
			plain_rgb_q  <= 1'b0;
			half_ticks_q <= 16'd6;
			cs_used_q    <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LED_COUNT:  led_count_q  <= pwdata[11:0];
				REG_PLAIN_RGB:  plain_rgb_q  <= pwdata[0];
				REG_HALF_TICKS: half_ticks_q <= pwdata[15:0];
				REG_CS_USED:    cs_used_q    <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LED_COUNT:  prdata = {20'b0, led_count_q};
			REG_PLAIN_RGB:  prdata = {31'b0, plain_rgb_q};
			REG_HALF_TICKS: prdata = {16'b0, half_ticks_q};
			REG_CS_USED:    prdata = {31'b0, cs_used_q};
			default:        prdata = '0;
		endcase
	end

	// handshakes: take a request while the skid entry is free and no clearing pass runs
	assign req.ready = !clearing_q && !skid_valid_q;
	assign in_acc    = req.valid && req.ready;
	assign drain     = res_valid_q && res.ready;

	// a count above the store depth acts as the depth
	assign eff_count = (32'(led_count_q) > 32'(MAX_LEDS)) ? FW'(MAX_LEDS) : FW'(led_count_q);
	assign idx_ok    = 32'(req.pixel_index) < 32'(eff_count);
	// zero half period acts as one
	assign half      = (half_ticks_q == 16'd0) ? 16'd1 : half_ticks_q;
	assign div_inc   = div_q + 16'd1;
	assign wp_inc    = wp_q + WPW'(1);

	// one pass per request
	always_comb begin
		shift_d   = shift_q;
		bits_d    = bits_q;
		wp_d      = wp_q;
		div_d     = div_q;
		clk_lvl_d = clk_lvl_q;
		active_d  = active_q;
		frame_d   = frame_q;
		status_d  = ST_OK;
		case (req.req_type)
			REQ_TICK: begin
				if (active_q) begin
					if (div_inc < half) begin
						div_d = div_inc;
					end else begin
						div_d = 16'd0;
						if (!clk_lvl_q) begin
							clk_lvl_d = 1'b1;
						end else begin
							clk_lvl_d = 1'b0;
							if (bits_q != 5'd0) begin
								shift_d = {shift_q[30:0], 1'b0};
								bits_d  = bits_q - 5'd1;
							end else if (wp_inc <= WPW'(frame_q)) begin
								// next led word, already read ahead from the store
								wp_d    = wp_inc;
								shift_d = ram_rdata;
								bits_d  = 5'd31;
							end else if (wp_inc == WPW'(frame_q) + WPW'(1)) begin
								wp_d    = wp_inc;
								shift_d = END_WORD;
								bits_d  = 5'd31;
							end else begin
								// frame done
								active_d = 1'b0;
								shift_d  = '0;
								bits_d   = 5'd0;
								wp_d     = '0;
								div_d    = 16'd0;
							end
						end
					end
				end
			end
			REQ_WRITE: begin
				if (!idx_ok) begin
					status_d = ST_RANGE;
				end
			end
			REQ_SHOW: begin
				if (active_q) begin
					status_d = ST_BUSY;
				end else begin
					frame_d   = eff_count;
					wp_d      = '0;
					shift_d   = START_WORD;
					bits_d    = 5'd31;
					div_d     = 16'd0;
					clk_lvl_d = 1'b0;
					active_d  = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res_d.sck      = active_d && clk_lvl_d;
		res_d.mosi     = active_d && shift_d[31];
		res_d.cs_n     = !(active_d && cs_used_q);
		res_d.busy_res = active_d;
		res_d.status   = status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= '0;
			bits_q    <= 5'd0;
			wp_q      <= '0;
			div_q     <= 16'd0;
			clk_lvl_q <= 1'b0;
			active_q  <= 1'b0;
			frame_q   <= '0;
		end else if (in_acc) begin
			shift_q   <= shift_d;
			bits_q    <= bits_d;
			wp_q      <= wp_d;
			div_q     <= div_d;
			clk_lvl_q <= clk_lvl_d;
			active_q  <= active_d;
			frame_q   <= frame_d;
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(MAX_LEDS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// store write: clearing pass, or an accepted in-range pixel write
	assign ram_we    = clearing_q || (in_acc && (req.req_type == REQ_WRITE) && idx_ok);
	assign ram_waddr = clearing_q ? clr_idx_q : AW'(req.pixel_index);
	assign ram_wdata = clearing_q ? 32'd0 :
		make_led_word(plain_rgb_q, req.red, req.green, req.blue, req.brightness);

	// read address is the led that the next word load takes
	lsft_ram #(
		.WIDTH (32),
		.DEPTH (MAX_LEDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (wp_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// output stage: result register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (drain) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_acc) begin
			if (res_valid_q && !drain) begin
				skid_valid_q <= 1'b1;
			end
			res_valid_q <= 1'b1;
		end else if (drain) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (drain) begin
				res_q <= skid_q;
			end
		end else if (in_acc) begin
			if (res_valid_q && !drain) begin
				skid_q <= res_d;
			end else begin
				res_q <= res_d;
			end
		end
	end

	assign res.valid    = res_valid_q;
	assign res.sck      = res_q.sck;
	assign res.mosi     = res_q.mosi;
	assign res.cs_n     = res_q.cs_n;
	assign res.busy_res = res_q.busy_res;
	assign res.status   = res_q.status;

`include "assert_macros.svh"

	// idle serialiser keeps shifter, bit count, word position and divider at zero
	`LSFT_ASSERT(a_idle_clean, !active_q |-> (shift_q == 32'd0 && bits_q == 5'd0 && wp_q == '0 && div_q == 16'd0), "idle serialiser state not clean")
	// word position never runs past the end word
	`LSFT_ASSERT(a_wp_bound, wp_q <= WPW'(frame_q) + WPW'(1), "word position past end of frame")
	// no request is taken while the store is being cleared
	`LSFT_ASSERT(a_no_acc_clear, clearing_q |-> !in_acc, "request taken during clearing pass")
	// a show taken while idle starts a frame and reports ok
	`LSFT_ASSERT_NEXT(a_show_start, in_acc && req.req_type == REQ_SHOW && !active_q && !res_valid_q, active_q && res.valid && res.busy_res && res.status == ST_OK, "show did not start a frame")

endmodule

// ===== hdl/lsft_ram.sv =====
module lsft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write-first: a read of the address being written returns the new data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== bench/testbench.sv =====
module testbench;
	import lsft_pkg::*;

	// request code with no operation behind it
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int STORE_DEPTH     = 2048;
	localparam int ITEM_TARGET     = 800;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER  = 200;
	localparam int SETTLE_CYCLES   = 4;
	localparam int DRAIN_CYCLES    = 10;

	// results that can be read off directly
	localparam res_t IDLE_OK = '{sck: 1'b0, mosi: 1'b0, cs_n: 1'b1, busy_res: 1'b0,
		status: ST_OK};
	localparam res_t IDLE_RANGE = '{sck: 1'b0, mosi: 1'b0, cs_n: 1'b1, busy_res: 1'b0,
		status: ST_RANGE};
	localparam res_t FRAME_STARTED = '{sck: 1'b0, mosi: 1'b0, cs_n: 1'b1, busy_res: 1'b1,
		status: ST_OK};
	localparam res_t SHOW_REFUSED = '{sck: 1'b0, mosi: 1'b0, cs_n: 1'b1, busy_res: 1'b1,
		status: ST_BUSY};

	typedef struct packed {
		logic [1:0]  req_type;
		logic [10:0] idx;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  bright;
	} pixel_req_t;

	// one row of the directed table: a register write or a request
	// code is the register index for a write, the request type otherwise
	// data is the register value, or {red, green, blue, brightness}
	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  code;
		logic [10:0] idx;
		logic [31:0] data;
		logic        typed;
		res_t        want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lsft_req_if req_ch();
	lsft_res_if res_ch();

	led_strip_spi_frame_transmitter #(
		.MAX_LEDS(STORE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the strip: pixel store, serialiser and registers
	logic [31:0] led_words [STORE_DEPTH];
	logic [31:0] shifter;
	int unsigned bits_rem;
	int unsigned word_pos;
	int unsigned frame_len;
	logic [15:0] div_cnt;
	logic        sck_lvl;
	logic        sending;
	logic [11:0] cfg_count;
	logic        cfg_rgb;
	logic [15:0] cfg_half;
	logic        cfg_cs;

	res_t        expected_lines [$];
	bit          sender_calm;
	int unsigned accepted_items;
	int unsigned working_items;
	int unsigned results_seen;
	int unsigned fails;
	int unsigned frames_sent;
	int unsigned range_refusals;
	int unsigned busy_refusals;
	int unsigned cycle_count;

	// directed part: extremes, every request type and the corner cases
	dir_row_t directed_rows [29] = '{
		// tick while idle, then the unused code
		'{1'b0, REQ_TICK,      11'd0,    32'h0000_0000, 1'b1, IDLE_OK},
		'{1'b0, REQ_UNUSED,    11'd0,    32'h0000_0000, 1'b1, IDLE_OK},
		// full brightness into the one led, then writes past the count
		'{1'b0, REQ_WRITE,     11'd0,    32'hFF00_80FF, 1'b1, IDLE_OK},
		'{1'b0, REQ_WRITE,     11'd1,    32'h0102_03FF, 1'b1, IDLE_RANGE},
		'{1'b0, REQ_WRITE,     11'd2047, 32'hFFFF_FFFF, 1'b1, IDLE_RANGE},
		// show, and a second show while the frame runs
		'{1'b0, REQ_SHOW,      11'd0,    32'h0000_0000, 1'b1, FRAME_STARTED},
		'{1'b0, REQ_SHOW,      11'd0,    32'h0000_0000, 1'b1, SHOW_REFUSED},
		// select switched on and count dropped to zero mid-frame
		'{1'b1, REG_CS_USED,   11'd0,    32'd1,         1'b0, IDLE_OK},
		'{1'b1, REG_LED_COUNT, 11'd0,    32'd0,         1'b0, IDLE_OK},
		'{1'b0, REQ_WRITE,     11'd0,    32'h0000_0000, 1'b0, IDLE_OK},
		'{1'b0, REQ_TICK,      11'd0,    32'h0000_0000, 1'b0, IDLE_OK},
		// zero half period acts as one
		'{1'b1, REG_HALF_TICKS, 11'd0,   32'd0,         1'b0, IDLE_OK},
		'{1'b0, REQ_TICK,      11'd0,    32'h0000_0000, 1'b0, IDLE_OK},
		'{1'b0, REQ_TICK,      11'd0,    32'h0000_0000, 1'b0, IDLE_OK},
		// longest half period, then back to the shortest
		'{1'b1, REG_HALF_TICKS, 11'd0,   32'd65535,     1'b0, IDLE_OK},
		'{1'b0, REQ_TICK,      11'd0,    32'h0000_0000, 1'b0, IDLE_OK},
		'{1'b0, REQ_TICK,      11'd0,    32'h0000_0000, 1'b0, IDLE_OK},
		'{1'b1, REG_HALF_TICKS, 11'd0,   32'd1,         1'b0, IDLE_OK},
		'{1'b0, REQ_TICK,      11'd0,    32'h0000_0000, 1'b0, IDLE_OK},
		// oversized count acts as the store depth
		'{1'b1, REG_LED_COUNT, 11'd0,    32'd4095,      1'b0, IDLE_OK},
		'{1'b0, REQ_WRITE,     11'd2047, 32'h1122_3300, 1'b0, IDLE_OK},
		// rgb word into a led not yet loaded by the running frame
		'{1'b1, REG_PLAIN_RGB, 11'd0,    32'd1,         1'b0, IDLE_OK},
		'{1'b0, REQ_WRITE,     11'd0,    32'h1234_5680, 1'b0, IDLE_OK},
		'{1'b1, REG_LED_COUNT, 11'd0,    32'd2048,      1'b0, IDLE_OK},
		'{1'b0, REQ_WRITE,     11'd1024, 32'h7F80_017F, 1'b0, IDLE_OK},
		// brightness rounding near the middle and at the bottom
		'{1'b1, REG_PLAIN_RGB, 11'd0,    32'd0,         1'b0, IDLE_OK},
		'{1'b0, REQ_WRITE,     11'd3,    32'h0102_037F, 1'b0, IDLE_OK},
		'{1'b0, REQ_WRITE,     11'd4,    32'h8000_0001, 1'b0, IDLE_OK},
		'{1'b0, REQ_WRITE,     11'd1023, 32'hAA55_AA55, 1'b0, IDLE_OK}
	};

	// count after clamping to the store depth
	function automatic int unsigned live_count();
		return (cfg_count > STORE_DEPTH) ? STORE_DEPTH : int'(cfg_count);
	endfunction

	// load the word at word_pos into the shifter; 0 once the end word is out
	function automatic bit load_frame_word();
		if (word_pos == 0) begin
			shifter = START_WORD;
		end else if (word_pos <= frame_len) begin
			shifter = led_words[word_pos - 1];
		end else if (word_pos == frame_len + 1) begin
			shifter = END_WORD;
		end else begin
			return 1'b0;
		end
		bits_rem = 31;
		return 1'b1;
	endfunction

	// one divider step of the serial line: low half, high half, next bit
	function automatic void advance_line();
		int unsigned half;
		half = (cfg_half == 16'd0) ? 1 : int'(cfg_half);
		if (!sending) begin
			return;
		end
		div_cnt = div_cnt + 16'd1;
		if (div_cnt < half) begin
			return;
		end
		div_cnt = '0;
		if (!sck_lvl) begin
			sck_lvl = 1'b1;
			return;
		end
		sck_lvl = 1'b0;
		if (bits_rem > 0) begin
			shifter = shifter << 1;
			bits_rem--;
			return;
		end
		word_pos++;
		if (!load_frame_word()) begin
			sending   = 1'b0;
			shifter   = '0;
			bits_rem  = 0;
			word_pos  = 0;
			div_cnt   = '0;
			frames_sent++;
		end
	endfunction

	function automatic logic [1:0] store_pixel(input pixel_req_t it);
		int unsigned level;
		if (it.idx >= live_count()) begin
			return ST_RANGE;
		end
		if (cfg_rgb) begin
			led_words[it.idx] = {it.red, it.green, it.blue, PAD_BYTE};
		end else begin
			// 8-bit brightness rounded onto the 5-bit global field
			level = (int'(it.bright) * 31 + 127) / 255;
			led_words[it.idx] = {LED_HDR | 8'(level), it.blue, it.green, it.red};
		end
		return ST_OK;
	endfunction

	function automatic logic [1:0] open_frame();
		if (sending) begin
			return ST_BUSY;
		end
		frame_len = live_count();
		word_pos  = 0;
		void'(load_frame_word());
		div_cnt   = '0;
		sck_lvl   = 1'b0;
		sending   = 1'b1;
		return ST_OK;
	endfunction

	// line state and status after one request
	function automatic res_t predict_line(input pixel_req_t it);
		res_t       line;
		logic [1:0] st;
		st = ST_OK;
		case (it.req_type)
			REQ_TICK:  advance_line();
			REQ_WRITE: st = store_pixel(it);
			REQ_SHOW:  st = open_frame();
			default:   ;
		endcase
		if (st == ST_RANGE) begin
			range_refusals++;
		end
		if (st == ST_BUSY) begin
			busy_refusals++;
		end
		line.sck      = sending & sck_lvl;
		line.mosi     = sending & shifter[31];
		line.cs_n     = !(sending && cfg_cs);
		line.busy_res = sending;
		line.status   = st;
		return line;
	endfunction

	// mostly back to back, sometimes a short gap, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// random request; write indices mostly near the count, some anywhere
	function automatic pixel_req_t random_req(input logic [1:0] code);
		pixel_req_t it;
		it.req_type = code;
		if ($urandom_range(0, 4) == 0) begin
			it.idx = 11'($urandom_range(0, STORE_DEPTH - 1));
		end else begin
			it.idx = 11'($urandom_range(0, live_count()));
		end
		{it.red, it.green, it.blue, it.bright} = $urandom();
		return it;
	endfunction

	// offer one request and hold it until the transfer
	task automatic send_req(input pixel_req_t it, input bit typed, input res_t want);
		int unsigned gap;
		res_t        line;
		gap = sender_calm ? 0 : pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= it.req_type;
		req_ch.pixel_index <= it.idx;
		req_ch.red         <= it.red;
		req_ch.green       <= it.green;
		req_ch.blue        <= it.blue;
		req_ch.brightness  <= it.bright;
		do @(posedge clk); while (!req_ch.ready);
		accepted_items++;
		// idle ticks and the unused code leave the block untouched
		if (it.req_type != REQ_UNUSED && !(it.req_type == REQ_TICK && !sending)) begin
			working_items++;
		end
		line = predict_line(it);
		expected_lines.push_back(typed ? want : line);
	endtask

	// apb write: setup phase, access phase, then the bus goes idle and the value is read back
	task automatic write_reg(input logic [1:0] sel, input logic [31:0] value);
		logic [31:0] readback;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		readback = '0;
		case (sel)
			REG_LED_COUNT: begin
				cfg_count = value[11:0];
				readback  = {20'b0, value[11:0]};
			end
			REG_PLAIN_RGB: begin
				cfg_rgb  = value[0];
				readback = {31'b0, value[0]};
			end
			REG_HALF_TICKS: begin
				cfg_half = value[15:0];
				readback = {16'b0, value[15:0]};
			end
			REG_CS_USED: begin
				cfg_cs   = value[0];
				readback = {31'b0, value[0]};
			end
			default:        ;
		endcase
		if (prdata !== readback) begin
			$error("prdata expected %0h got %0h", readback, prdata);
			fails++;
		end
	endtask

	// stop offering and let every outstanding result drain
	task automatic settle(input int unsigned extra);
		req_ch.valid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// stimulus: reset, directed table, then random phases
	initial begin
		dir_row_t    row;
		pixel_req_t  it;
		int unsigned tick_cap;
		int unsigned ticks;
		int unsigned pick;
		logic [1:0]  code;
		logic [11:0] new_count;
		logic [15:0] new_half;

		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_TICK;
		req_ch.pixel_index <= '0;
		req_ch.red         <= '0;
		req_ch.green       <= '0;
		req_ch.blue        <= '0;
		req_ch.brightness  <= '0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;

		// shadow matches the block once its clearing pass is done
		foreach (led_words[i]) begin
			led_words[i] = '0;
		end
		shifter   = '0;
		bits_rem  = 0;
		word_pos  = 0;
		frame_len = 0;
		div_cnt   = '0;
		sck_lvl   = 1'b0;
		sending   = 1'b0;
		cfg_count = 12'd1;
		cfg_rgb   = 1'b0;
		cfg_half  = 16'd6;
		cfg_cs    = 1'b0;
		sender_calm = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				settle(SETTLE_CYCLES);
				write_reg(row.code, row.data);
			end else begin
				it.req_type = row.code;
				it.idx      = row.idx;
				{it.red, it.green, it.blue, it.bright} = row.data;
				send_req(it, row.typed, row.want);
			end
		end

		// random phases: new settings, then noise or a few writes, a show and the ticks to send it;
		// some phases are cut short so the next settings land mid-frame
		while (working_items < ITEM_TARGET) begin
			settle(SETTLE_CYCLES);
			sender_calm = ($urandom_range(0, 2) == 0);
			case ($urandom_range(0, 9))
				0:       new_count = 12'd0;
				7, 8:    new_count = 12'($urandom_range(4, 6));
				9:       new_count = 12'd1;
				default: new_count = 12'($urandom_range(1, 3));
			endcase
			if (new_count <= 1 && $urandom_range(0, 3) == 0) begin
				new_half = 16'd2;
			end else if ($urandom_range(0, 7) == 0) begin
				new_half = 16'd0;
			end else begin
				new_half = 16'd1;
			end
			write_reg(REG_LED_COUNT, 32'(new_count));
			write_reg(REG_HALF_TICKS, 32'(new_half));
			if ($urandom_range(0, 1) == 1) begin
				write_reg(REG_PLAIN_RGB, 32'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 1) == 1) begin
				write_reg(REG_CS_USED, 32'($urandom_range(0, 1)));
			end

			if ($urandom_range(0, 5) == 0) begin
				// noise: any request code in any order
				repeat (20) send_req(random_req(2'($urandom_range(0, 3))), 1'b0, IDLE_OK);
			end else begin
				repeat ($urandom_range(0, 4)) send_req(random_req(REQ_WRITE), 1'b0, IDLE_OK);
				send_req(random_req(REQ_SHOW), 1'b0, IDLE_OK);
				tick_cap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 200) : CYCLE_LIMIT;
				ticks = 0;
				while (sending && ticks < tick_cap && working_items < ITEM_TARGET) begin
					pick = $urandom_range(0, 39);
					if (pick == 0) begin
						code = REQ_SHOW;
					end else if (pick == 1) begin
						code = REQ_UNUSED;
					end else if (pick < 4) begin
						code = REQ_WRITE;
					end else begin
						code = REQ_TICK;
					end
					send_req(random_req(code), 1'b0, IDLE_OK);
					ticks++;
				end
			end
		end

		settle(DRAIN_CYCLES);
		$display("%0d requests transferred, %0d of them doing work, %0d results checked",
			accepted_items, working_items, results_seen);
		$display("%0d frames sent out, %0d writes out of range, %0d shows refused while busy",
			frames_sent, range_refusals, busy_refusals);
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// result side: random stalls, and once a long hold-off so the block backs up
	initial begin
		int unsigned stall;
		bit          held;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (!held && results_seen >= HOLD_OFF_AFTER) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			stall = pick_gap();
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// compare every result transfer with the oldest expected line state
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (expected_lines.size() == 0) begin
				$error("result transfer with nothing expected");
				fails++;
			end else begin
				want = expected_lines.pop_front();
				if (res_ch.sck !== want.sck) begin
					$error("sck expected %0d got %0d", want.sck, res_ch.sck);
					fails++;
				end
				if (res_ch.mosi !== want.mosi) begin
					$error("mosi expected %0d got %0d", want.mosi, res_ch.mosi);
					fails++;
				end
				if (res_ch.cs_n !== want.cs_n) begin
					$error("cs_n expected %0d got %0d", want.cs_n, res_ch.cs_n);
					fails++;
				end
				if (res_ch.busy_res !== want.busy_res) begin
					$error("busy_res expected %0d got %0d", want.busy_res, res_ch.busy_res);
					fails++;
				end
				if (res_ch.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, res_ch.status);
					fails++;
				end
			end
		end
	end

	// watchdog, sized well past the slowest correct run including the clearing pass
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped at the cycle limit with %0d results outstanding",
			expected_lines.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
